### hw/rtl/i8mm_pkg.sv
// ----------------------------------------------------------------------------
// i8mm_pkg: shared definitions for the int8 matrix multiply block
// Store bounds, opcodes, register indexes and the control bundle that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package i8mm_pkg;

  // Default store bounds.
  localparam int unsigned MaxRowsDef  = 64;
  localparam int unsigned MaxColsDef  = 64;
  localparam int unsigned MaxInnerDef = 64;

  // Field widths of the streaming items.
  localparam int unsigned IdxW  = 6;
  localparam int unsigned ElemW = 8;
  localparam int unsigned AccW  = 32;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned OpW   = 2;

  // Packed widths of the stream payloads (rounded up to whole bytes).
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // Item opcodes.
  localparam logic [OpW-1:0] OpLoadA   = 2'd0;
  localparam logic [OpW-1:0] OpLoadB   = 2'd1;
  localparam logic [OpW-1:0] OpCompute = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegRowsOfA    = 2'd0;
  localparam logic [1:0] RegColsOfB    = 2'd1;
  localparam logic [1:0] RegInnerLen   = 2'd2;

  // Control bundle for the multiply-accumulate unit.
  typedef struct packed {
    logic clear;   // start a new dot product
    logic enable;  // operand pair is valid this cycle
  } mac_ctrl_t;

endpackage

### hw/rtl/int8_matrix_multiply.sv
// ----------------------------------------------------------------------------
// int8_matrix_multiply: signed 8-bit matrix multiply, 32-bit accumulation
// Load items fill the A and B element stores; a compute item walks one row
// of A and one column of B through a shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Transfer carries
//   s_axis   in         tuser: opcode; tdata: row, column, element byte
//   m_axis   out        tdata: result value, result row, result column
//   apb      in/out     register writes and reads (M, N, K)
//
// A load leaves the block in the idle state, so the input stays ready after it.
// During a compute, one memory read per cycle from each store port feeds the
// single multiply-accumulate unit, and the result drains through the read,
// multiply and accumulate registers. The input is not ready while a compute runs.
// The finished result waits in an output register, so loads go on while it
// is stalled; a further compute holds at its end until the register frees.
// Reset clears control state; the element stores are not cleared.
// ----------------------------------------------------------------------------
module int8_matrix_multiply #(
  parameter int unsigned MAX_ROWS  = i8mm_pkg::MaxRowsDef,
  parameter int unsigned MAX_COLS  = i8mm_pkg::MaxColsDef,
  parameter int unsigned MAX_INNER = i8mm_pkg::MaxInnerDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [i8mm_pkg::InDataW-1:0]  s_axis_tdata,  // row[5:0], col[11:6], elem[19:12]
  input  logic [i8mm_pkg::OpW-1:0]      s_axis_tuser,  // opcode[1:0]
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [i8mm_pkg::OutDataW-1:0] m_axis_tdata,  // value[31:0], row[37:32], col[43:38]
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned DepthA = MAX_ROWS * MAX_INNER;
  localparam int unsigned DepthB = MAX_INNER * MAX_COLS;
  localparam int unsigned AwA    = (DepthA > 1) ? $clog2(DepthA) : 1;
  localparam int unsigned AwB    = (DepthB > 1) ? $clog2(DepthB) : 1;
  localparam int unsigned IdxW   = i8mm_pkg::IdxW;
  localparam int unsigned CfgW   = i8mm_pkg::CfgW;
  localparam int unsigned ElemW  = i8mm_pkg::ElemW;
  localparam int unsigned AccW   = i8mm_pkg::AccW;

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // Unpacked input fields.
  logic [IdxW-1:0]             in_row, in_col;
  logic signed [ElemW-1:0]     in_elem;
  logic [i8mm_pkg::OpW-1:0]    in_op;
  logic                        in_xfer;

  assign in_row  = s_axis_tdata[IdxW-1:0];
  assign in_col  = s_axis_tdata[2*IdxW-1:IdxW];
  assign in_elem = s_axis_tdata[2*IdxW+ElemW-1:2*IdxW];
  assign in_op   = s_axis_tuser;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  logic [CfgW-1:0] rows_q, cols_q, inner_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CfgW'(64);
      cols_q  <= CfgW'(64);
      inner_q <= CfgW'(64);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        i8mm_pkg::RegRowsOfA:  rows_q  <= pwdata[CfgW-1:0];
        i8mm_pkg::RegColsOfB:  cols_q  <= pwdata[CfgW-1:0];
        i8mm_pkg::RegInnerLen: inner_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      i8mm_pkg::RegRowsOfA:  prdata = 32'(rows_q);
      i8mm_pkg::RegColsOfB:  prdata = 32'(cols_q);
      i8mm_pkg::RegInnerLen: prdata = 32'(inner_q);
      default:               prdata = '0;
    endcase
  end

  // Effective inner length, bounded by the store depth.
  logic [CfgW-1:0] k_eff;
  assign k_eff = (32'(inner_q) > MAX_INNER) ? CfgW'(MAX_INNER) : inner_q;

  // Range checks on the incoming item.
  logic load_a_ok, load_b_ok, comp_ok;
  assign load_a_ok = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_INNER);
  assign load_b_ok = (32'(in_row) < MAX_INNER) && (32'(in_col) < MAX_COLS);
  assign comp_ok   = ({1'b0, in_row} < rows_q) && (32'(in_row) < MAX_ROWS) &&
                     ({1'b0, in_col} < cols_q) && (32'(in_col) < MAX_COLS);

  // Sequencer registers.
  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] row_q, row_d, col_q, col_d;
  logic [CfgW-1:0] klen_q, klen_d, p_q, p_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_vld_q, out_vld_d;
  logic [i8mm_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic            start;
  logic            issue;
  logic            mac_busy;
  logic [AccW-1:0] mac_acc;
  i8mm_pkg::mac_ctrl_t mac_ctrl;

  assign s_axis_tready = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    klen_d     = klen_q;
    p_d        = p_q;
    rd_vld_d   = 1'b0;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    start      = 1'b0;
    issue      = 1'b0;

    // The output register empties on a transfer.
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer && (in_op == i8mm_pkg::OpCompute) && comp_ok) begin
          row_d   = in_row;
          col_d   = in_col;
          klen_d  = k_eff;
          p_d     = '0;
          start   = 1'b1;
          state_d = StRun;
        end
      end
      StRun: begin
        if (p_q < klen_q) begin
          issue    = 1'b1;
          rd_vld_d = 1'b1;
          p_d      = p_q + CfgW'(1);
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Wait for the pipeline to drain and the output register to free.
        if (!rd_vld_q && !mac_busy && (!out_vld_q || m_axis_tready)) begin
          out_vld_d  = 1'b1;
          out_data_d = i8mm_pkg::OutDataW'({col_q, row_q, mac_acc});
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      p_q       <= '0;
      klen_q    <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      p_q       <= p_d;
      klen_q    <= klen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Store addresses: A is row-major by inner index, B row-major by column.
  logic [31:0]    a_waddr_w, b_waddr_w, a_raddr_w, b_raddr_w;
  logic [AwA-1:0] a_waddr, a_raddr;
  logic [AwB-1:0] b_waddr, b_raddr;
  logic           a_we, b_we;

  assign a_waddr_w = 32'(in_row) * MAX_INNER + 32'(in_col);
  assign b_waddr_w = 32'(in_row) * MAX_COLS + 32'(in_col);
  assign a_raddr_w = 32'(row_q) * MAX_INNER + 32'(p_q);
  assign b_raddr_w = 32'(p_q) * MAX_COLS + 32'(col_q);
  assign a_waddr   = a_waddr_w[AwA-1:0];
  assign b_waddr   = b_waddr_w[AwB-1:0];
  assign a_raddr   = a_raddr_w[AwA-1:0];
  assign b_raddr   = b_raddr_w[AwB-1:0];

  assign a_we = in_xfer && (in_op == i8mm_pkg::OpLoadA) && load_a_ok;
  assign b_we = in_xfer && (in_op == i8mm_pkg::OpLoadB) && load_b_ok;

  // Element stores: one write port and one registered read port each.
  logic signed [ElemW-1:0] a_mem [DepthA];
  logic signed [ElemW-1:0] b_mem [DepthB];
  logic signed [ElemW-1:0] a_rd_q, b_rd_q;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= in_elem;
    end
    if (issue) begin
      a_rd_q <= a_mem[a_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[b_waddr] <= in_elem;
    end
    if (issue) begin
      b_rd_q <= b_mem[b_raddr];
    end
  end

  // Shared multiply-accumulate unit.
  assign mac_ctrl.clear  = start;
  assign mac_ctrl.enable = rd_vld_q;

  i8mm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

endmodule

### hw/rtl/i8mm_mac.sv
// ----------------------------------------------------------------------------
// i8mm_mac: shared signed multiply-accumulate unit
// One 8x8 signed multiply per cycle into a product register, then a 32-bit
// accumulate. The sequencer feeds one operand pair per cycle.
// ----------------------------------------------------------------------------
module i8mm_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  i8mm_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [i8mm_pkg::ElemW-1:0]   a_i,
  input  logic signed [i8mm_pkg::ElemW-1:0]   b_i,
  output logic        [i8mm_pkg::AccW-1:0]    acc_o,
  output logic                                busy_o
);

  localparam int unsigned ProdW = 2 * i8mm_pkg::ElemW;

  logic signed [ProdW-1:0]          prod_q;
  logic                             prod_vld_q;
  logic        [i8mm_pkg::AccW-1:0] acc_q, acc_d;

  // Multiply stage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.enable) begin
      prod_q <= a_i * b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.enable;
    end
  end

  // Accumulate stage: wraps modulo 2^32 like two's complement addition.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(i8mm_pkg::AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule
